// ----- rtl/core/fba_pkg.sv -----
// ---------------------------------------------------------------------------
// fba_pkg - frame bitmap allocator shared definitions
// Field widths, request and status codes, and controller state encoding.
// ---------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    localparam int unsigned NUM_FRAMES_DEFAULT = 4096;
    localparam int unsigned WORD_BITS          = 32;
    localparam int unsigned PAGE_SHIFT         = 12;
    localparam int unsigned ADDR_W             = 32;
    localparam int unsigned FRAME_W            = 20;
    localparam int unsigned IN_TDATA_W         = 56;
    localparam int unsigned OUT_TDATA_W        = 32;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_MAP   = 2'd1,
        FUNC_MARK  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        STATUS_MAPPED  = 3'd0,
        STATUS_ALREADY = 3'd1,
        STATUS_NOFREE  = 3'd2,
        STATUS_RANGE   = 3'd3,
        STATUS_MARKED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_MARK,
        FSM_RESULT
    } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/core/fba_bitmap_ram.sv -----
// ---------------------------------------------------------------------------
// fba_bitmap_ram - bitmap word store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_bitmap_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [AW-1:0]                    wr_addr,
    input  wire logic [fba_pkg::WORD_BITS-1:0]    wr_data,
    input  wire logic                             rd_en,
    input  wire logic [AW-1:0]                    rd_addr,
    output logic      [fba_pkg::WORD_BITS-1:0]    rd_data
);

    logic [fba_pkg::WORD_BITS-1:0] mem [DEPTH];
    logic [fba_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/frame_bitmap_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// frame_bitmap_allocator_unit - first-fit physical frame allocator
// Used/free bitmap of 4 KiB frames in a word memory; allocates the lowest
// free frame, maps a given address or marks an address's frame used.
// ---------------------------------------------------------------------------
//  channel | dir | ports                         | payload
//  s_      | in  | s_tvalid s_tready s_tdata[55:0] | request
//  m_      | out | m_tvalid m_tready m_tdata[31:0] | result
//
// Sequencing: one request at a time. Already-mapped / range / unused codes
// go straight to the result state, map and mark add a memory read and write
// back, allocate scans bitmap words (one word per cycle through the single
// read port), up to FRAME_WORDS, and writes back the word with a free bit.
// Reset: a clearing pass writes zero to all FRAME_WORDS words, s_tready
// stays low meanwhile.
// Stalls: a finished result holds in the output register; the next request
// is taken while it waits and completes once the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_unit #(
    parameter int unsigned NUM_FRAMES = fba_pkg::NUM_FRAMES_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // func[1:0], paddr[33:2], entry_frame[53:34], kernel_flag[54],
    // write_flag[55]
    input  wire logic [fba_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[2:0], frame_number[22:3], present[23], writable[24],
    // user_mode[25], zero[31:26]
    output logic      [fba_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned FRAME_WORDS = (NUM_FRAMES + 31) / 32;
    localparam int unsigned WORD_AW     = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int unsigned TAIL_BITS   = NUM_FRAMES % 32;
    localparam logic [31:0] TAIL_MASK   =
        (TAIL_BITS == 0) ? 32'd0 : ~((32'd1 << TAIL_BITS) - 32'd1);
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(FRAME_WORDS - 1);
    localparam logic [fba_pkg::FRAME_W:0] NUM_FRAMES_L = (fba_pkg::FRAME_W + 1)'(NUM_FRAMES);

    // request fields
    logic [1:0]                   s_func;
    logic [fba_pkg::FRAME_W-1:0]  s_addr_frame;
    logic [fba_pkg::FRAME_W-1:0]  s_entry;
    logic                         s_kernel;
    logic                         s_wr;
    logic                         s_in_range;

    assign s_func       = s_tdata[1:0];
    assign s_addr_frame = s_tdata[33:14];
    assign s_entry      = s_tdata[53:34];
    assign s_kernel     = s_tdata[54];
    assign s_wr         = s_tdata[55];
    assign s_in_range   = {1'b0, s_addr_frame} < NUM_FRAMES_L;

    fba_pkg::fsm_t                state_reg, state_next;
    logic [WORD_AW-1:0]           ptr_reg, ptr_next;
    fba_pkg::status_t             status_reg, status_next;
    logic [fba_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic [fba_pkg::FRAME_W-1:0]  req_frame_reg, req_frame_next;
    logic                         req_map_reg, req_map_next;
    logic                         req_kernel_reg, req_kernel_next;
    logic                         req_wr_reg, req_wr_next;

    logic                         m_valid_reg, m_valid_next;
    fba_pkg::status_t             m_status_reg, m_status_next;
    logic [fba_pkg::FRAME_W-1:0]  m_frame_reg, m_frame_next;
    logic                         m_flags_en;
    logic                         m_present_reg, m_writable_reg, m_user_reg;

    // memory port signals
    logic                         wr_en, rd_en;
    logic [WORD_AW-1:0]           wr_addr, rd_addr;
    logic [31:0]                  wr_data, rd_data;

    // scan word: out-of-range tail bits read as used
    logic [31:0]                  scan_word;
    logic [31:0]                  free_bits;
    logic                         free_found;
    logic [4:0]                   free_idx;
    logic                         s_xfer;
    logic                         out_free;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign scan_word  = rd_data | ((ptr_reg == LAST_WORD) ? TAIL_MASK : 32'd0);
    assign free_bits  = ~scan_word;
    assign free_found = |free_bits;

    always_comb begin
        free_idx = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = 5'(i);
            end
        end
    end

    fba_bitmap_ram #(
        .DEPTH (FRAME_WORDS),
        .AW    (WORD_AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fba_pkg::FSM_CLEAR;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg     <= status_next;
        frame_reg      <= frame_next;
        req_frame_reg  <= req_frame_next;
        req_map_reg    <= req_map_next;
        req_kernel_reg <= req_kernel_next;
        req_wr_reg     <= req_wr_next;
        m_status_reg   <= m_status_next;
        m_frame_reg    <= m_frame_next;
        if (m_flags_en) begin
            m_present_reg  <= (status_reg == fba_pkg::STATUS_MAPPED);
            m_writable_reg <= (status_reg == fba_pkg::STATUS_MAPPED) && req_wr_reg;
            m_user_reg     <= (status_reg == fba_pkg::STATUS_MAPPED) && !req_kernel_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        status_next     = status_reg;
        frame_next      = frame_reg;
        req_frame_next  = req_frame_reg;
        req_map_next    = req_map_reg;
        req_kernel_next = req_kernel_reg;
        req_wr_next     = req_wr_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_frame_next    = m_frame_reg;
        m_flags_en      = 1'b0;
        s_tready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = 32'd0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            fba_pkg::FSM_CLEAR: begin
                wr_en = 1'b1;
                if (ptr_reg == LAST_WORD) begin
                    ptr_next   = '0;
                    state_next = fba_pkg::FSM_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            fba_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_xfer) begin
                    req_frame_next  = s_addr_frame;
                    req_kernel_next = s_kernel;
                    req_wr_next     = s_wr;
                    req_map_next    = (s_func == fba_pkg::FUNC_MAP);
                    frame_next      = '0;
                    state_next      = fba_pkg::FSM_RESULT;
                    case (s_func)
                        fba_pkg::FUNC_ALLOC: begin
                            if (s_entry != '0) begin
                                status_next = fba_pkg::STATUS_ALREADY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = fba_pkg::FSM_SCAN;
                            end
                        end
                        fba_pkg::FUNC_MAP, fba_pkg::FUNC_MARK: begin
                            if ((s_func == fba_pkg::FUNC_MAP) && (s_entry != '0)) begin
                                status_next = fba_pkg::STATUS_ALREADY;
                            end else if (s_in_range) begin
                                rd_en      = 1'b1;
                                rd_addr    = WORD_AW'(s_addr_frame >> 5);
                                state_next = fba_pkg::FSM_MARK;
                            end else begin
                                status_next = fba_pkg::STATUS_RANGE;
                            end
                        end
                        default: begin
                            status_next = fba_pkg::STATUS_RANGE;
                        end
                    endcase
                end
            end

            fba_pkg::FSM_SCAN: begin
                if (free_found) begin
                    wr_en       = 1'b1;
                    wr_addr     = ptr_reg;
                    wr_data     = rd_data | (32'd1 << free_idx);
                    status_next = fba_pkg::STATUS_MAPPED;
                    frame_next  = fba_pkg::FRAME_W'({ptr_reg, free_idx});
                    state_next  = fba_pkg::FSM_RESULT;
                end else if (ptr_reg == LAST_WORD) begin
                    status_next = fba_pkg::STATUS_NOFREE;
                    state_next  = fba_pkg::FSM_RESULT;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            fba_pkg::FSM_MARK: begin
                wr_en      = 1'b1;
                wr_addr    = WORD_AW'(req_frame_reg >> 5);
                wr_data    = rd_data | (32'd1 << req_frame_reg[4:0]);
                state_next = fba_pkg::FSM_RESULT;
                if (req_map_reg) begin
                    status_next = fba_pkg::STATUS_MAPPED;
                    frame_next  = req_frame_reg;
                end else begin
                    status_next = fba_pkg::STATUS_MARKED;
                end
            end

            fba_pkg::FSM_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_frame_next  = frame_reg;
                    m_flags_en    = 1'b1;
                    state_next    = fba_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = fba_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_user_reg, m_writable_reg, m_present_reg,
                       m_frame_reg, m_status_reg};

`ifndef NO_ASSERTIONS
    // one request in flight: after a transfer the input side closes
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in flight");

    // present bit only with a mapped status
    a_present_mapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23] == (m_tdata[2:0] == fba_pkg::STATUS_MAPPED)))
        else $error("present bit disagrees with status");

    // bitmap written only by clear pass, scan hit or mark
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == fba_pkg::FSM_CLEAR || state_reg == fba_pkg::FSM_SCAN ||
                   state_reg == fba_pkg::FSM_MARK))
        else $error("bitmap write outside clear/scan/mark");
`endif

endmodule

`default_nettype wire
